[src/ctt_pkg.sv]
// Shared types and codes for the challenge token table.
`default_nettype none
package ctt_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int STAT_W = 3;
    localparam int OCC_W  = 5;
    localparam int REQ_W  = 2;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_ISSUE    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_VALIDATE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CONSUME  = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_VALID    = 3'd0;
    localparam logic [STAT_W-1:0] ST_UNKNOWN  = 3'd1;
    localparam logic [STAT_W-1:0] ST_MISMATCH = 3'd2;
    localparam logic [STAT_W-1:0] ST_EXPIRED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_CONSUMED = 3'd4;

    // configuration register indexes
    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_TTL      = 1'b1;

    localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
    localparam logic [DATA_W-1:0] TTL_RESET = 32'd5000;

    typedef struct packed {
        logic              used;
        logic [DATA_W-1:0] serial;
        logic [DATA_W-1:0] expiry;
        logic [DATA_W-1:0] issue;
        logic [DATA_W-1:0] token;
        logic [DATA_W-1:0] host;
    } entry_t;

endpackage
`default_nettype wire

[src/challenge_token_table_core.sv]
// Top level of the challenge token table: sequencer, entry memory and result register.
`default_nettype none
// One request walks the whole table through a single read port, one entry per
// cycle, while one compare unit sorts out expiry, host and token matches and
// tracks the oldest survivor. An issue then passes through a place step before
// the result step; a validate or consume goes straight to the result step.
// s_tready rises again in the same cycle the result is loaded, so a new request
// is taken only after the previous result is loaded; a stalled result beat holds
// the block in its last step. Configuration writes are taken at any time and
// must only come while the block is idle.
module challenge_token_table_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [95:0]                 s_tdata,   // host_addr, challenge, now
    input  wire logic [ctt_pkg::REQ_W-1:0]   s_tuser,   // req_type
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // status, expiry drops, host replaced, oldest dropped, occupancy, pad
    output logic [15:0]                      m_tdata,
    input  wire logic                        cfg_wr_en,
    input  wire logic                        cfg_index,
    input  wire logic [ctt_pkg::DATA_W-1:0]  cfg_data
);
    import ctt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CTR_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CTR_W > CAP_W) ? CTR_W : CAP_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_PLACE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // control state
    logic [1:0]             state_reg, state_next;
    logic [CTR_W-1:0]       addr_reg, addr_next;
    logic                   proc_vld_reg, proc_vld_next;
    logic [IDX_W-1:0]       proc_idx_reg, proc_idx_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [CTR_W-1:0]       occ_reg, occ_next;
    logic [DATA_W-1:0]      serial_reg, serial_next;
    logic [CAP_W-1:0]       cap_reg;
    logic [DATA_W-1:0]      ttl_reg;
    logic                   out_vld_reg, out_vld_next;

    // per-request accumulators
    logic [CTR_W-1:0]       exp_cnt_reg, exp_cnt_next;
    logic [CTR_W-1:0]       held_reg, held_next;
    logic                   replaced_reg, replaced_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [DATA_W-1:0]      best_time_reg, best_time_next;
    logic [DATA_W-1:0]      best_serial_reg, best_serial_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   seen_reg, seen_next;
    logic                   matched_reg, matched_next;
    logic [STAT_W-1:0]      mstat_reg, mstat_next;
    logic                   evicted_reg, evicted_next;

    // request payload
    logic [REQ_W-1:0]       req_reg;
    logic [DATA_W-1:0]      host_reg, tok_reg, now_reg;
    logic [15:0]            out_data_reg, out_data_next;

    // entry memory
    entry_t                 mem [TABLE_DEPTH];
    entry_t                 rd_data_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic                   rd_en;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    entry_t                 wr_data;

    // datapath helpers
    logic                   cur_valid;
    logic                   exp_hit;
    logic                   older;
    logic [CMP_W-1:0]       cap_eff;
    logic                   do_evict;
    logic                   have_slot;
    logic [IDX_W-1:0]       new_slot;
    logic [DATA_W:0]        exp_sum;
    logic [DATA_W-1:0]      exp_sat;
    logic [STAT_W-1:0]      final_stat;
    logic                   is_issue;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign is_issue = (req_reg == REQ_ISSUE);

    assign cur_valid = valid_reg[proc_idx_reg];
    assign exp_hit   = (now_reg >= rd_data_reg.expiry);
    assign older     = (rd_data_reg.issue < best_time_reg) ||
                       ((rd_data_reg.issue == best_time_reg) &&
                        (rd_data_reg.serial < best_serial_reg));

    always_comb
    begin
        cap_eff = CMP_W'(cap_reg);
        if (cap_eff == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_eff > CMP_W'(TABLE_DEPTH))
        begin
            cap_eff = CMP_W'(TABLE_DEPTH);
        end
    end

    assign do_evict  = (CMP_W'(held_reg) >= cap_eff) && found_reg;
    assign have_slot = do_evict || free_found_reg;
    assign new_slot  = (do_evict && (!free_found_reg || (best_idx_reg < free_idx_reg))) ?
                       best_idx_reg : free_idx_reg;
    assign exp_sum   = {1'b0, now_reg} + {1'b0, ttl_reg};
    assign exp_sat   = exp_sum[DATA_W] ? {DATA_W{1'b1}} : exp_sum[DATA_W-1:0];
    assign final_stat = matched_reg ? mstat_reg : (seen_reg ? ST_MISMATCH : ST_UNKNOWN);

    always_comb
    begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        proc_vld_next    = 1'b0;
        proc_idx_next    = proc_idx_reg;
        valid_next       = valid_reg;
        occ_next         = occ_reg;
        serial_next      = serial_reg;
        out_vld_next     = out_vld_reg;
        out_data_next    = out_data_reg;
        exp_cnt_next     = exp_cnt_reg;
        held_next        = held_reg;
        replaced_next    = replaced_reg;
        found_next       = found_reg;
        best_idx_next    = best_idx_reg;
        best_time_next   = best_time_reg;
        best_serial_next = best_serial_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        seen_next        = seen_reg;
        matched_next     = matched_reg;
        mstat_next       = mstat_reg;
        evicted_next     = evicted_reg;
        rd_en            = 1'b0;
        rd_addr          = addr_reg[IDX_W-1:0];
        wr_en            = 1'b0;
        wr_addr          = proc_idx_reg;
        wr_data          = rd_data_reg;

        if (out_vld_reg && m_tready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next      = S_SCAN;
                    addr_next       = '0;
                    exp_cnt_next    = '0;
                    held_next       = '0;
                    replaced_next   = 1'b0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    seen_next       = 1'b0;
                    matched_next    = 1'b0;
                    evicted_next    = 1'b0;
                end
            end
            S_SCAN:
            begin
                // issue the next read while the previous entry is examined
                if (addr_reg < CTR_W'(TABLE_DEPTH))
                begin
                    rd_en         = 1'b1;
                    addr_next     = addr_reg + CTR_W'(1);
                    proc_vld_next = 1'b1;
                    proc_idx_next = addr_reg[IDX_W-1:0];
                end
                if (proc_vld_reg)
                begin
                    if (is_issue)
                    begin
                        if (cur_valid && exp_hit)
                        begin
                            valid_next[proc_idx_reg] = 1'b0;
                            exp_cnt_next = exp_cnt_reg + CTR_W'(1);
                        end
                        else if (cur_valid && !replaced_reg && (rd_data_reg.host == host_reg))
                        begin
                            valid_next[proc_idx_reg] = 1'b0;
                            replaced_next = 1'b1;
                        end
                        else if (cur_valid)
                        begin
                            held_next = held_reg + CTR_W'(1);
                            if (!found_reg || older)
                            begin
                                found_next       = 1'b1;
                                best_idx_next    = proc_idx_reg;
                                best_time_next   = rd_data_reg.issue;
                                best_serial_next = rd_data_reg.serial;
                            end
                        end
                        // a slot freed here or never used is a candidate home
                        if (!valid_next[proc_idx_reg] && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = proc_idx_reg;
                        end
                    end
                    else if (cur_valid && (rd_data_reg.token == tok_reg))
                    begin
                        seen_next = 1'b1;
                        if (!matched_reg && (rd_data_reg.host == host_reg))
                        begin
                            matched_next = 1'b1;
                            if (exp_hit)
                            begin
                                mstat_next = ST_EXPIRED;
                            end
                            else if (rd_data_reg.used)
                            begin
                                mstat_next = ST_CONSUMED;
                            end
                            else
                            begin
                                mstat_next = ST_VALID;
                                if (req_reg == REQ_CONSUME)
                                begin
                                    wr_en        = 1'b1;
                                    wr_data.used = 1'b1;
                                end
                            end
                        end
                    end
                    if (addr_reg == CTR_W'(TABLE_DEPTH))
                    begin
                        state_next = is_issue ? S_PLACE : S_DONE;
                    end
                end
            end
            S_PLACE:
            begin
                if (do_evict)
                begin
                    valid_next[best_idx_reg] = 1'b0;
                end
                if (have_slot)
                begin
                    valid_next[new_slot] = 1'b1;
                    wr_en          = 1'b1;
                    wr_addr        = new_slot;
                    wr_data.used   = 1'b0;
                    wr_data.serial = serial_reg;
                    wr_data.expiry = exp_sat;
                    wr_data.issue  = now_reg;
                    wr_data.token  = tok_reg;
                    wr_data.host   = host_reg;
                    serial_next    = serial_reg + DATA_W'(1);
                end
                occ_next     = held_reg + CTR_W'(have_slot) - CTR_W'(do_evict);
                evicted_next = do_evict;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                // hold until the result register is free
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next = 1'b1;
                    if (is_issue)
                    begin
                        out_data_next = {1'b0, OCC_W'(occ_reg), evicted_reg, replaced_reg,
                                         OCC_W'(exp_cnt_reg), ST_VALID};
                    end
                    else
                    begin
                        out_data_next = {1'b0, OCC_W'(occ_reg), 1'b0, 1'b0,
                                         OCC_W'(0), final_stat};
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            addr_reg     <= '0;
            proc_vld_reg <= 1'b0;
            valid_reg    <= '0;
            occ_reg      <= '0;
            serial_reg   <= '0;
            cap_reg      <= CAP_RESET;
            ttl_reg      <= TTL_RESET;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            proc_vld_reg <= proc_vld_next;
            valid_reg    <= valid_next;
            occ_reg      <= occ_next;
            serial_reg   <= serial_next;
            out_vld_reg  <= out_vld_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_CAPACITY: cap_reg <= cfg_data[CAP_W-1:0];
                    CFG_TTL:      ttl_reg <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    // payload and accumulator registers
    always_ff @(posedge clk)
    begin
        proc_idx_reg    <= proc_idx_next;
        exp_cnt_reg     <= exp_cnt_next;
        held_reg        <= held_next;
        replaced_reg    <= replaced_next;
        found_reg       <= found_next;
        best_idx_reg    <= best_idx_next;
        best_time_reg   <= best_time_next;
        best_serial_reg <= best_serial_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        seen_reg        <= seen_next;
        matched_reg     <= matched_next;
        mstat_reg       <= mstat_next;
        evicted_reg     <= evicted_next;
        out_data_reg    <= out_data_next;
        if (s_tvalid && s_tready)
        begin
            req_reg  <= s_tuser;
            host_reg <= s_tdata[31:0];
            tok_reg  <= s_tdata[63:32];
            now_reg  <= s_tdata[95:64];
        end
    end

    // entry memory: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[src/ctt_checker.sv]
// Port-level assertions for the challenge token table, bound to the top level.
`default_nettype none
module ctt_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [15:0]                 m_tdata
);
    import ctt_pkg::*;

    // busy after a request beat until its result is built
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one in flight");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] <= ST_CONSUMED))
        else $error("status code out of range");

    // only an issue reports removals, and an issue always reports success
    a_counts_issue_only: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:0] != ST_VALID)) |->
        ((m_tdata[7:3] == 5'd0) && !m_tdata[8] && !m_tdata[9]))
        else $error("removal counts on a validate result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

endmodule

bind challenge_token_table_core ctt_checker u_ctt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
